// File: hdl/opmac_pkg.sv
// Shared types and constants for the 4x4 outer-product MAC tile.
// No dependencies; every other file of the tile but opmac_chan_if imports this package.
package opmac_pkg;

   // Tile geometry and field widths
   localparam int TILE      = 4;
   localparam int OPND_BITS = 16;
   localparam int PROD_BITS = 2 * OPND_BITS;
   localparam int OUT_BITS  = 48;
   localparam int ROW_BITS  = 2;
   localparam int CNT_BITS  = 3;

   // Input transfer: one A column and one B row at a single depth step
   typedef struct packed {
      logic signed [OPND_BITS-1:0] a_row0;
      logic signed [OPND_BITS-1:0] a_row1;
      logic signed [OPND_BITS-1:0] a_row2;
      logic signed [OPND_BITS-1:0] a_row3;
      logic signed [OPND_BITS-1:0] b_col0;
      logic signed [OPND_BITS-1:0] b_col1;
      logic signed [OPND_BITS-1:0] b_col2;
      logic signed [OPND_BITS-1:0] b_col3;
      logic                        last_step;
   } req_payload_type;

   // Result transfer: one row of the C tile
   typedef struct packed {
      logic [ROW_BITS-1:0]        row_index;
      logic signed [OUT_BITS-1:0] c_col0;
      logic signed [OUT_BITS-1:0] c_col1;
      logic signed [OUT_BITS-1:0] c_col2;
      logic signed [OUT_BITS-1:0] c_col3;
      logic                       last_row;
   } rsp_payload_type;

   // Control shared by all cells of the tile
   typedef struct packed {
      logic load;     // capture new operands into the product register
      logic commit;   // add the registered product into the accumulator
      logic clear;    // final step of a tile: hand off the sum and zero the accumulator
      logic advance;  // shift the drain chain one row toward the output
   } cell_ctrl_type;

endpackage

// File: hdl/opmac_chan_if.sv
// Valid/ready stream channel with a typed payload.
// Depends on nothing; the payload type is given at instantiation.
interface opmac_chan_if #(
   parameter type payload_type = logic
) ();

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface

// File: hdl/opmac_cell.sv
// One multiply-accumulate cell of the tile plus its slot in the drain chain.
// Depends on opmac_pkg.
module opmac_cell #(
   parameter int ACC_BITS = 48
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  opmac_pkg::cell_ctrl_type             ctrl,
   input  logic signed [opmac_pkg::OPND_BITS-1:0] a_in,
   input  logic signed [opmac_pkg::OPND_BITS-1:0] b_in,
   input  logic signed [opmac_pkg::OUT_BITS-1:0]  drain_from,
   output logic signed [opmac_pkg::OUT_BITS-1:0]  drain_out
);
   import opmac_pkg::*;

   localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
   localparam logic signed [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};
   localparam logic signed [OUT_BITS-1:0] OUT_MAX = {1'b0, {(OUT_BITS-1){1'b1}}};
   localparam logic signed [OUT_BITS-1:0] OUT_MIN = {1'b1, {(OUT_BITS-1){1'b0}}};

   logic signed [PROD_BITS-1:0] prod_ff;
   logic signed [ACC_BITS-1:0]  acc_ff, acc_in;
   logic signed [OUT_BITS-1:0]  drain_ff, drain_in;
   logic signed [ACC_BITS:0]    sum;
   logic signed [ACC_BITS-1:0]  sat_sum;
   logic signed [OUT_BITS-1:0]  sat_out;

   // Register the product ahead of the adder
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         prod_ff <= a_in * b_in;
      end
   end

   // Add one bit of headroom, then clamp to the accumulator range
   always_comb begin
      sum = (ACC_BITS+1)'(acc_ff) + (ACC_BITS+1)'(prod_ff);
      if (sum[ACC_BITS] != sum[ACC_BITS-1]) begin
         sat_sum = sum[ACC_BITS] ? ACC_MIN : ACC_MAX;
      end else begin
         sat_sum = sum[ACC_BITS-1:0];
      end
   end

   // Fit the accumulator to the output width
   generate
      if (ACC_BITS > OUT_BITS) begin : g_clamp
         logic [ACC_BITS-OUT_BITS:0] upper;
         always_comb begin
            upper = sat_sum[ACC_BITS-1:OUT_BITS-1];
            if ((&upper) || !(|upper)) begin
               sat_out = sat_sum[OUT_BITS-1:0];
            end else if (sat_sum[ACC_BITS-1]) begin
               sat_out = OUT_MIN;
            end else begin
               sat_out = OUT_MAX;
            end
         end
      end else begin : g_extend
         assign sat_out = OUT_BITS'(sat_sum);
      end
   endgenerate

   // Accumulate, or restart the tile after the final step
   always_comb begin
      acc_in = acc_ff;
      if (ctrl.commit) begin
         acc_in = ctrl.clear ? '0 : sat_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   // Load the finished sum or take the value of the neighbor below
   always_comb begin
      drain_in = drain_ff;
      priority if (ctrl.commit && ctrl.clear) begin
         drain_in = sat_out;
      end else if (ctrl.advance) begin
         drain_in = drain_from;
      end
   end

   always_ff @(posedge clock) begin
      drain_ff <= drain_in;
   end

   assign drain_out = drain_ff;

endmodule

// File: hdl/outer_product_mac_tile_4x4.sv
// 4x4 outer-product MAC tile. Each req transfer carries one column of the A tile and one row
// of the B tile; all sixteen products are added into saturating ACC_BITS accumulators held in
// a 4x4 array of cells, one product register and one adder per cell. Within a tile a step is
// taken every cycle while req offers one. The step marked last_step hands the sixteen sums
// to a drain chain that shifts one row per cycle toward rsp while rsp takes it, rows 0 to 3
// in order, and zeroes the accumulators. While the product stage holds that final step and
// while the chain still holds rows, req is not ready.
// Depends on opmac_pkg, opmac_chan_if and opmac_cell.
module outer_product_mac_tile_4x4 #(
   parameter int ACC_BITS = 48
) (
   input  logic         clock,
   input  logic         reset,
   opmac_chan_if.sink   req_chan,
   opmac_chan_if.source rsp_chan
);
   import opmac_pkg::*;

   logic                        accept;
   logic                        rsp_xfer;
   logic                        p_valid_ff, p_valid_in;
   logic                        p_last_ff, p_last_in;
   logic [CNT_BITS-1:0]         drain_cnt_ff, drain_cnt_in;
   cell_ctrl_type               ctrl;
   logic signed [OPND_BITS-1:0] a_vec [TILE];
   logic signed [OPND_BITS-1:0] b_vec [TILE];
   logic signed [OUT_BITS-1:0]  drain [TILE][TILE];

   // Operand fan-out
   assign a_vec[0] = req_chan.payload.a_row0;
   assign a_vec[1] = req_chan.payload.a_row1;
   assign a_vec[2] = req_chan.payload.a_row2;
   assign a_vec[3] = req_chan.payload.a_row3;
   assign b_vec[0] = req_chan.payload.b_col0;
   assign b_vec[1] = req_chan.payload.b_col1;
   assign b_vec[2] = req_chan.payload.b_col2;
   assign b_vec[3] = req_chan.payload.b_col3;

   // Hold off new steps while a finished tile is in flight
   assign req_chan.ready = (drain_cnt_ff == '0) && !p_last_ff;
   assign accept         = req_chan.valid && req_chan.ready;
   assign rsp_xfer       = rsp_chan.valid && rsp_chan.ready;

   // Track the product stage
   assign p_valid_in = accept;
   assign p_last_in  = accept && req_chan.payload.last_step;

   // Count rows left in the drain chain
   always_comb begin
      drain_cnt_in = drain_cnt_ff;
      priority if (p_last_ff) begin
         drain_cnt_in = CNT_BITS'(TILE);
      end else if (rsp_xfer) begin
         drain_cnt_in = drain_cnt_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff   <= 1'b0;
         p_last_ff    <= 1'b0;
         drain_cnt_ff <= '0;
      end else begin
         p_valid_ff   <= p_valid_in;
         p_last_ff    <= p_last_in;
         drain_cnt_ff <= drain_cnt_in;
      end
   end

   assign ctrl.load    = accept;
   assign ctrl.commit  = p_valid_ff;
   assign ctrl.clear   = p_last_ff;
   assign ctrl.advance = rsp_xfer;

   // Cell array; drains move from row TILE-1 toward row 0
   for (genvar i = 0; i < TILE; i++) begin : g_row
      for (genvar j = 0; j < TILE; j++) begin : g_col
         logic signed [OUT_BITS-1:0] from_below;
         if (i == TILE - 1) begin : g_tail
            assign from_below = '0;
         end else begin : g_link
            assign from_below = drain[i+1][j];
         end
         opmac_cell #(
            .ACC_BITS (ACC_BITS)
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (ctrl),
            .a_in       (a_vec[i]),
            .b_in       (b_vec[j]),
            .drain_from (from_below),
            .drain_out  (drain[i][j])
         );
      end
   end

   // Present the head of the drain chain
   assign rsp_chan.valid             = (drain_cnt_ff != '0);
   assign rsp_chan.payload.row_index = ROW_BITS'(CNT_BITS'(TILE) - drain_cnt_ff);
   assign rsp_chan.payload.c_col0    = drain[0][0];
   assign rsp_chan.payload.c_col1    = drain[0][1];
   assign rsp_chan.payload.c_col2    = drain[0][2];
   assign rsp_chan.payload.c_col3    = drain[0][3];
   assign rsp_chan.payload.last_row  = (drain_cnt_ff == CNT_BITS'(1));

endmodule

// File: hdl/opmac_checker.sv
// Port-level checks for outer_product_mac_tile_4x4, attached by the bind below.
// Depends on opmac_pkg and the tile's top level.
module opmac_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       req_last_step,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input opmac_pkg::rsp_payload_type rsp_payload
);
   import opmac_pkg::*;

   // A stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("rsp payload changed while stalled");

   // Rows of a tile come out in order
   a_row_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_payload.last_row |=>
         rsp_valid && (rsp_payload.row_index ==
                       ROW_BITS'($past(rsp_payload.row_index) + ROW_BITS'(1))))
      else $error("tile rows out of order");

   // The final row flag marks row 3 only
   a_last_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.last_row == (rsp_payload.row_index == ROW_BITS'(TILE - 1))))
      else $error("last_row does not match row_index");

   // No step is taken while a tile drains, nor right after a final step
   a_drain_block: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid |-> !req_ready) and
      (req_valid && req_ready && req_last_step |=> !req_ready))
      else $error("step transfer overlaps tile drain");

endmodule

bind outer_product_mac_tile_4x4 opmac_checker u_opmac_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .req_last_step (req_chan.payload.last_step),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_payload   (rsp_chan.payload)
);

// File: bench/opmac_tb_pkg.sv
// Scoreboard for the 4x4 outer-product MAC tile bench: predicts the tile rows and checks them.
// Depends on opmac_pkg for the transfer payload types and the tile geometry.
package opmac_tb_pkg;
   import opmac_pkg::*;

   // Accumulator width used for both the predictor and the block instance
   localparam int     SUM_BITS = 48;
   localparam longint SUM_MAX  = (longint'(1) << (SUM_BITS - 1)) - 1;
   localparam longint SUM_MIN  = -SUM_MAX - 1;
   localparam int     REPORT_LIMIT = 10;

   class tile_scoreboard;
      longint          sums[TILE][TILE];
      rsp_payload_type rows_due[$];
      int unsigned     errors;

      function new();
         errors = 0;
         clear_sums();
      endfunction

      function void clear_sums();
         for (int i = 0; i < TILE; i++)
            for (int j = 0; j < TILE; j++)
               sums[i][j] = 0;
      endfunction

      function int unsigned pending();
         return rows_due.size();
      endfunction

      // Count a failure; only the first few get printed
      function void record(string msg);
         errors++;
         if (errors <= REPORT_LIMIT)
            $display("%0t: %s", $time, msg);
      endfunction

      // Fold one accepted depth step into the tile sums; on the last step queue four rows
      function void note_step(req_payload_type s);
         longint          a[TILE];
         longint          b[TILE];
         longint          total;
         rsp_payload_type r;
         a[0] = $signed(s.a_row0);
         a[1] = $signed(s.a_row1);
         a[2] = $signed(s.a_row2);
         a[3] = $signed(s.a_row3);
         b[0] = $signed(s.b_col0);
         b[1] = $signed(s.b_col1);
         b[2] = $signed(s.b_col2);
         b[3] = $signed(s.b_col3);
         // products stay within 2^30, so the 64-bit sum cannot wrap before the clamp
         for (int i = 0; i < TILE; i++)
            for (int j = 0; j < TILE; j++) begin
               total = sums[i][j] + a[i] * b[j];
               if (total > SUM_MAX)
                  total = SUM_MAX;
               else if (total < SUM_MIN)
                  total = SUM_MIN;
               sums[i][j] = total;
            end
         if (s.last_step) begin
            for (int i = 0; i < TILE; i++) begin
               r.row_index = i[ROW_BITS-1:0];
               r.c_col0    = sums[i][0][OUT_BITS-1:0];
               r.c_col1    = sums[i][1][OUT_BITS-1:0];
               r.c_col2    = sums[i][2][OUT_BITS-1:0];
               r.c_col3    = sums[i][3][OUT_BITS-1:0];
               r.last_row  = (i == TILE - 1);
               rows_due.push_back(r);
            end
            clear_sums();
         end
      endfunction

      function void compare_field(string name, logic signed [63:0] want,
                                  logic signed [63:0] got);
         if (got !== want)
            record($sformatf("row mismatch on %s: expected %0d, got %0d", name, want, got));
      endfunction

      // Match one accepted row against the oldest row still due
      function void check_row(rsp_payload_type got);
         rsp_payload_type want;
         if (rows_due.size() == 0) begin
            record($sformatf("unexpected row %0d with no tile pending", got.row_index));
            return;
         end
         want = rows_due.pop_front();
         compare_field("row_index", want.row_index, got.row_index);
         compare_field("c_col0", $signed(want.c_col0), $signed(got.c_col0));
         compare_field("c_col1", $signed(want.c_col1), $signed(got.c_col1));
         compare_field("c_col2", $signed(want.c_col2), $signed(got.c_col2));
         compare_field("c_col3", $signed(want.c_col3), $signed(got.c_col3));
         compare_field("last_row", want.last_row, got.last_row);
      endfunction
   endclass

endpackage

// File: bench/tb_outer_product_mac_tile_4x4.sv
// Top-level bench for the 4x4 outer-product MAC tile: directed tiles with extreme operands,
// then random tiles under shifting stall patterns and one long result hold-off.
// Depends on opmac_pkg, opmac_chan_if, opmac_tb_pkg and the tile RTL.
module tb_outer_product_mac_tile_4x4;
   import opmac_pkg::*;
   import opmac_tb_pkg::*;

   localparam int     HALF_PERIOD = 5;
   localparam longint LIMIT_CYCLES = 1000000;
   localparam int     HOLD_CYCLES = 64;
   localparam int     DRAIN_CYCLES = 20;

   logic        clock = 1'b0;
   logic        reset;
   logic        hold_arm = 1'b0;
   int unsigned send_idle_pct = 24;
   int unsigned recv_idle_pct = 80;

   tile_scoreboard tile_check = new();

   opmac_chan_if #(.payload_type(req_payload_type)) req_chan ();
   opmac_chan_if #(.payload_type(rsp_payload_type)) rsp_chan ();

   outer_product_mac_tile_4x4 #(
      .ACC_BITS (SUM_BITS)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #HALF_PERIOD clock = ~clock;

   // Watch both channels and feed every transfer to the scoreboard
   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready)
         tile_check.note_step(req_chan.payload);
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         tile_check.check_row(rsp_chan.payload);
   end

   // Result side: random stalls, plus one long hold-off once armed
   initial begin : row_sink
      int unsigned hold_left;
      logic        hold_taken;
      hold_left  = 0;
      hold_taken = 1'b0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_chan.ready <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (hold_arm && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Hard stop in case the block hangs
   initial begin : watchdog
      #(2 * HALF_PERIOD * LIMIT_CYCLES);
      $display("tb_outer_product_mac_tile_4x4: errors");
      $finish;
   end

   function automatic req_payload_type make_step(logic [15:0] a0, logic [15:0] a1,
                                                 logic [15:0] a2, logic [15:0] a3,
                                                 logic [15:0] b0, logic [15:0] b1,
                                                 logic [15:0] b2, logic [15:0] b3,
                                                 logic last);
      req_payload_type s;
      s.a_row0    = a0;
      s.a_row1    = a1;
      s.a_row2    = a2;
      s.a_row3    = a3;
      s.b_col0    = b0;
      s.b_col1    = b1;
      s.b_col2    = b2;
      s.b_col3    = b3;
      s.last_step = last;
      return s;
   endfunction

   // Bias operands toward the extremes and small values, with plenty of full-range noise
   function automatic logic [15:0] pick_operand();
      logic [15:0] v;
      case ($urandom_range(7))
         0: v = 16'h8000;
         1: v = 16'h7FFF;
         2: v = 16'h0000;
         3: v = 16'hFFFF;
         4, 5: v = 16'($urandom_range(2047)) - 16'd1024;
         default: v = 16'($urandom);
      endcase
      return v;
   endfunction

   // Offer one depth step, idling first at the current rate, and hold until it transfers
   task automatic send_step(input req_payload_type s);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.payload <= s;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic directed_tiles();
      // single-step tiles: zeros, largest positive product, largest negative product
      send_step(make_step('0, '0, '0, '0, '0, '0, '0, '0, 1'b1));
      send_step(make_step(16'h8000, 16'h8000, 16'h8000, 16'h8000,
                          16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1));
      send_step(make_step(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                          16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1));
      // two-step tile with mixed signs, then a small correction on the last step
      send_step(make_step(16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF,
                          16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001, 1'b0));
      send_step(make_step(16'h0100, 16'hFF00, 16'h0080, 16'hFF80,
                          16'h0100, 16'h0100, 16'hFF00, 16'h0001, 1'b1));
      // scaled identity A (256 on the diagonal) against a B tile: C comes back as 256 times B
      send_step(make_step(16'h0100, 16'h0000, 16'h0000, 16'h0000,
                          16'h1234, 16'hEDCB, 16'h0001, 16'h7FFF, 1'b0));
      send_step(make_step(16'h0000, 16'h0100, 16'h0000, 16'h0000,
                          16'h8000, 16'h00FF, 16'hFF01, 16'h0200, 1'b0));
      send_step(make_step(16'h0000, 16'h0000, 16'h0100, 16'h0000,
                          16'h5555, 16'hAAAA, 16'h0F0F, 16'hF0F0, 1'b0));
      send_step(make_step(16'h0000, 16'h0000, 16'h0000, 16'h0100,
                          16'hFFFF, 16'h0000, 16'h3C3C, 16'hC3C3, 1'b1));
      // three identical extreme steps accumulated into one tile
      for (int k = 0; k < 3; k++)
         send_step(make_step(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF,
                             16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, k == 2));
   endtask

   // Whole tiles of random depth, mostly short with the odd deep one
   task automatic random_tiles(input int unsigned step_count);
      int unsigned sent;
      int unsigned depth;
      sent = 0;
      while (sent < step_count) begin
         depth = ($urandom_range(9) == 0) ? $urandom_range(20, 9) : $urandom_range(6, 1);
         for (int unsigned k = 0; k < depth; k++) begin
            send_step(make_step(pick_operand(), pick_operand(), pick_operand(),
                                pick_operand(), pick_operand(), pick_operand(),
                                pick_operand(), pick_operand(), k == depth - 1));
            sent++;
         end
      end
   endtask

   initial begin : stimulus
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.payload = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // sender idles lightly, receiver heavily
      directed_tiles();
      random_tiles(70);

      // swap the stall pattern
      send_idle_pct <= 80;
      recv_idle_pct <= 24;
      random_tiles(75);

      // no idling; the receiver takes one long hold-off while steps keep coming
      send_idle_pct <= 0;
      recv_idle_pct <= 0;
      hold_arm      <= 1'b1;
      random_tiles(75);
      req_chan.valid <= 1'b0;

      // wait for the last rows, then watch for strays
      while (tile_check.pending() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (tile_check.errors == 0)
         $display("tb_outer_product_mac_tile_4x4: clean");
      else
         $display("tb_outer_product_mac_tile_4x4: errors");
      $finish;
   end

endmodule

// File: files.f
hdl/opmac_pkg.sv
hdl/opmac_chan_if.sv
hdl/opmac_cell.sv
hdl/outer_product_mac_tile_4x4.sv
hdl/opmac_checker.sv
bench/opmac_tb_pkg.sv
bench/tb_outer_product_mac_tile_4x4.sv
